// ----- design/als_pkg.sv -----
package als_pkg;

  localparam int VERTEX_COUNT = 1024;
  localparam int MAX_DEGREE   = 32;

  localparam int VERT_W  = 10;
  localparam int VSTORE  = (VERTEX_COUNT < (1 << VERT_W)) ? VERTEX_COUNT : (1 << VERT_W);
  localparam int VA_W    = $clog2(VSTORE);
  localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
  localparam int SLOT_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int SLOT_DEPTH = VSTORE * (1 << SLOT_W);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_NEIGHBOUR = 2'd0,
    STAT_ADDED     = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_CHECK,
    BK_WRITE_B,
    BK_QEMIT
  } bk_state_t;

  typedef struct packed {
    op_t               op;
    logic [VERT_W-1:0] va;
    logic [VERT_W-1:0] vb;
    logic              a_bad;
    logic              b_bad;
    logic              self_loop;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

// ----- design/als_ram.sv -----
module als_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/als_front.sv -----
module als_front import als_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              opcode,
  input  logic [VERT_W-1:0] vertex_a,
  input  logic [VERT_W-1:0] vertex_b,
  input  logic              clearing,
  input  logic              pop,
  output queue_head_t       head
);

  item_t              entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               do_pop;
  item_t              classified;

  always_comb begin
    classified.op        = op_t'(opcode);
    classified.va        = vertex_a;
    classified.vb        = vertex_b;
    classified.a_bad     = {1'b0, vertex_a} >= (VERT_W + 1)'(VSTORE);
    classified.b_bad     = {1'b0, vertex_b} >= (VERT_W + 1)'(VSTORE);
    classified.self_loop = vertex_a == vertex_b;
  end

  assign item_ready = (count != QCNT_W'(QDEPTH)) && !clearing;
  assign push       = item_valid && item_ready;
  assign do_pop     = pop && (count != '0);

  assign head.valid = count != '0;
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/als_back.sv -----
module als_back import als_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  queue_head_t       head,
  output logic              pop,
  output logic              clearing,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [VERT_W-1:0] neighbour,
  output logic [1:0]        status,
  output logic              last
);

  bk_state_t state;
  bk_state_t state_next;
  item_t     cur;

  logic [VA_W-1:0]   clr_addr;
  logic [DEG_W-1:0]  k;

  logic              deg_re;
  logic [VA_W-1:0]   deg_raddr_a;
  logic [VA_W-1:0]   deg_raddr_b;
  logic              deg_we;
  logic [VA_W-1:0]   deg_waddr;
  logic [DEG_W-1:0]  deg_wdata;
  logic [DEG_W-1:0]  deg_a;
  logic [DEG_W-1:0]  deg_b;

  logic                          slot_we;
  logic [VA_W+SLOT_W-1:0]        slot_waddr;
  logic [VERT_W-1:0]             slot_wdata;
  logic                          slot_re;
  logic [VA_W+SLOT_W-1:0]        slot_raddr;
  logic [VERT_W-1:0]             slot_rdata;

  logic              out_free;
  logic              emit;
  logic [VERT_W-1:0] emit_nb;
  stat_t             emit_status;
  logic              emit_last;

  logic [DEG_W:0]    need;
  logic              full_a;
  logic              full_b;
  logic              add_drop;
  logic              q_empty;
  logic [DEG_W:0]    idx_b;
  logic [DEG_W:0]    k_inc;
  logic              q_last;

  als_ram #(.WIDTH(DEG_W), .DEPTH(VSTORE)) u_deg_a (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr_a),
    .rdata (deg_a)
  );

  als_ram #(.WIDTH(DEG_W), .DEPTH(VSTORE)) u_deg_b (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .re    (deg_re),
    .raddr (deg_raddr_b),
    .rdata (deg_b)
  );

  als_ram #(.WIDTH(VERT_W), .DEPTH(SLOT_DEPTH)) u_slots (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  assign out_free = !result_valid || result_ready;
  assign clearing = state == BK_CLEAR;

  assign need     = cur.self_loop ? (DEG_W + 1)'(2) : (DEG_W + 1)'(1);
  assign full_a   = ({1'b0, deg_a} + need) > (DEG_W + 1)'(MAX_DEGREE);
  assign full_b   = ({1'b0, deg_b} + need) > (DEG_W + 1)'(MAX_DEGREE);
  assign add_drop = cur.a_bad || cur.b_bad || full_a || full_b;
  assign q_empty  = cur.a_bad || (deg_a == '0);
  assign idx_b    = cur.self_loop ? ({1'b0, deg_b} + 1'b1) : {1'b0, deg_b};
  assign k_inc    = {1'b0, k} + 1'b1;
  assign q_last   = k_inc == {1'b0, deg_a};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_addr == VA_W'(VSTORE - 1)) begin
          state_next = BK_FETCH;
        end
      end
      BK_FETCH: begin
        if (head.valid) begin
          state_next = BK_CHECK;
        end
      end
      BK_CHECK: begin
        if (cur.op == OP_ADD) begin
          if (!add_drop) begin
            state_next = BK_WRITE_B;
          end else if (out_free) begin
            state_next = BK_FETCH;
          end
        end else begin
          if (!q_empty) begin
            state_next = BK_QEMIT;
          end else if (out_free) begin
            state_next = BK_FETCH;
          end
        end
      end
      BK_WRITE_B: begin
        if (out_free) begin
          state_next = BK_FETCH;
        end
      end
      BK_QEMIT: begin
        if (out_free && q_last) begin
          state_next = BK_FETCH;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // datapath controls
  always_comb begin
    pop         = 1'b0;
    deg_re      = 1'b0;
    deg_raddr_a = head.item.va[VA_W-1:0];
    deg_raddr_b = head.item.vb[VA_W-1:0];
    deg_we      = 1'b0;
    deg_waddr   = clr_addr;
    deg_wdata   = '0;
    slot_we     = 1'b0;
    slot_waddr  = {cur.va[VA_W-1:0], deg_a[SLOT_W-1:0]};
    slot_wdata  = cur.vb;
    slot_re     = 1'b0;
    slot_raddr  = {cur.va[VA_W-1:0], SLOT_W'(0)};
    emit        = 1'b0;
    emit_nb     = '0;
    emit_status = STAT_FULL;
    emit_last   = 1'b1;
    unique case (state)
      BK_CLEAR: begin
        deg_we = 1'b1;
      end
      BK_FETCH: begin
        pop    = head.valid;
        deg_re = head.valid;
      end
      BK_CHECK: begin
        if (cur.op == OP_ADD) begin
          if (!add_drop) begin
            slot_we   = 1'b1;
            deg_we    = 1'b1;
            deg_waddr = cur.va[VA_W-1:0];
            deg_wdata = DEG_W'({1'b0, deg_a} + 1'b1);
          end else begin
            emit        = out_free;
            emit_status = STAT_FULL;
          end
        end else begin
          if (!q_empty) begin
            slot_re = 1'b1;
          end else begin
            emit        = out_free;
            emit_status = STAT_EMPTY;
          end
        end
      end
      BK_WRITE_B: begin
        slot_waddr  = {cur.vb[VA_W-1:0], idx_b[SLOT_W-1:0]};
        slot_wdata  = cur.va;
        deg_waddr   = cur.vb[VA_W-1:0];
        deg_wdata   = DEG_W'(idx_b + 1'b1);
        slot_we     = out_free;
        deg_we      = out_free;
        emit        = out_free;
        emit_status = STAT_ADDED;
      end
      BK_QEMIT: begin
        emit        = out_free;
        emit_nb     = slot_rdata;
        emit_status = STAT_NEIGHBOUR;
        emit_last   = q_last;
        slot_re     = out_free && !q_last;
        slot_raddr  = {cur.va[VA_W-1:0], k_inc[SLOT_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.item;
    end
    if (state == BK_CHECK) begin
      k <= '0;
    end else if (state == BK_QEMIT && slot_re) begin
      k <= k_inc[DEG_W-1:0];
    end
    if (emit) begin
      neighbour <= emit_nb;
      status    <= emit_status;
      last      <= emit_last;
    end
  end

endmodule

// ----- design/adjacency_list_store_core.sv -----
// channel  | handshake                    | payload
// item     | item_valid / item_ready      | opcode, vertex_a, vertex_b
// result   | result_valid / result_ready  | neighbour, status, last
//
// an add edge goes through the back end in order: queue pop with degree read, check
// with first list write, second list write with status
// a query pops with degree read, checks with first slot read, then emits its stored neighbours
// one at a time (slot memory read port); empty, dropped and out of range items end in the check state
// after reset a clearing pass over all 1024 entries zeroes the degree memory; item_ready is low
// a held result stalls the back end; the 2-entry queue keeps taking items until it is full
module adjacency_list_store_core import als_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic              opcode,
  input  logic [VERT_W-1:0] vertex_a,
  input  logic [VERT_W-1:0] vertex_b,
  output logic              result_valid,
  input  logic              result_ready,
  output logic [VERT_W-1:0] neighbour,
  output logic [1:0]        status,
  output logic              last
);

  queue_head_t head;
  logic        pop;
  logic        clearing;

  als_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .opcode     (opcode),
    .vertex_a   (vertex_a),
    .vertex_b   (vertex_b),
    .clearing   (clearing),
    .pop        (pop),
    .head       (head)
  );

  als_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .neighbour    (neighbour),
    .status       (status),
    .last         (last)
  );

endmodule

// ----- design/als_checker.sv -----
module als_checker import als_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              opcode,
  input logic [VERT_W-1:0] vertex_a,
  input logic [VERT_W-1:0] vertex_b,
  input logic              result_valid,
  input logic              result_ready,
  input logic [VERT_W-1:0] neighbour,
  input logic [1:0]        status,
  input logic              last
);

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(opcode)
      && $stable(vertex_a) && $stable(vertex_b))
    else $error("item changed while waiting");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(neighbour)
      && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  a_zero_neighbour: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STAT_NEIGHBOUR |-> neighbour == '0)
    else $error("neighbour not zero on status result");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STAT_NEIGHBOUR |-> last)
    else $error("status result not marked last");

  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !item_ready && !result_valid)
    else $error("item taken during clearing pass");

endmodule

bind adjacency_list_store_core als_checker u_als_checker (.*);
